FILE: hw/rtl/mcr_pkg.sv
// ----------------------------------------------------------------------------
// mcr_pkg
// shared constants, types and register codes of the midpoint circle rasterizer
// ----------------------------------------------------------------------------
package mcr_pkg;

    localparam int COORD_BITS_DEF = 12;
    localparam int QUEUE_DEPTH_DEF = 2;

    localparam int MAX_RADIUS  = 63;
    localparam int MAX_RESULTS = 48;

    localparam int RAD_W   = 6;
    localparam int COL_W   = 4;
    localparam int CEN_W   = 10;
    localparam int POINT_W = 24;
    localparam int AB_W    = 8;
    localparam int D_W     = 10;
    localparam int CNT_W   = 6;
    localparam int CFG_IDX_W = 1;

    // decision rule constants
    localparam int D_BIAS    = 3;
    localparam int STEP_KEEP = 6;
    localparam int STEP_DIAG = 10;

    localparam logic [CEN_W-1:0] CENTER_X_RESET = CEN_W'(300);
    localparam logic [CEN_W-1:0] CENTER_Y_RESET = CEN_W'(200);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CENTER_X = 1'b0,
        CFG_CENTER_Y = 1'b1
    } t_cfg_idx;

    typedef struct packed {
        logic [RAD_W-1:0]        radius;
        logic [COL_W-1:0]        colour;
        logic signed [D_W-1:0]   d_init;
    } t_job;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_RUN  = 2'b10
    } t_back_state;

endpackage

FILE: hw/rtl/mcr_if.sv
// ----------------------------------------------------------------------------
// mcr channel interfaces
// request, pixel and configuration channels with valid/ready handshake
// ----------------------------------------------------------------------------
interface mcr_req_if;
    import mcr_pkg::*;

    logic             valid;
    logic             ready;
    logic [RAD_W-1:0] radius;
    logic [COL_W-1:0] pen_colour;

    modport source (output valid, output radius, output pen_colour, input ready);
    modport sink   (input valid, input radius, input pen_colour, output ready);
endinterface

interface mcr_pix_if;
    import mcr_pkg::*;

    logic               valid;
    logic               ready;
    logic [POINT_W-1:0] oct1_point;
    logic [POINT_W-1:0] oct2_point;
    logic [POINT_W-1:0] oct3_point;
    logic [POINT_W-1:0] oct4_point;
    logic [POINT_W-1:0] oct5_point;
    logic [POINT_W-1:0] oct6_point;
    logic [POINT_W-1:0] oct7_point;
    logic [POINT_W-1:0] oct8_point;
    logic [COL_W-1:0]   pixel_colour;
    logic               last_step;

    modport source (
        output valid, output oct1_point, output oct2_point, output oct3_point,
        output oct4_point, output oct5_point, output oct6_point, output oct7_point,
        output oct8_point, output pixel_colour, output last_step, input ready
    );
    modport sink (
        input valid, input oct1_point, input oct2_point, input oct3_point,
        input oct4_point, input oct5_point, input oct6_point, input oct7_point,
        input oct8_point, input pixel_colour, input last_step, output ready
    );
endinterface

interface mcr_cfg_if;
    import mcr_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [CEN_W-1:0]     data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: hw/rtl/mcr_front.sv
// ----------------------------------------------------------------------------
// mcr_front
// takes circle requests, clamps the radius and forms the starting decision value
// ----------------------------------------------------------------------------
module mcr_front (
    mcr_req_if.sink          i_req,
    output logic             o_job_valid,
    input  logic             i_job_ready,
    output mcr_pkg::t_job    o_job
);
    import mcr_pkg::*;

    logic [RAD_W-1:0]      rad_sat;
    logic signed [D_W-1:0] rad_ext;

    always_comb begin
        if (i_req.radius > RAD_W'(MAX_RADIUS)) begin
            rad_sat = RAD_W'(MAX_RADIUS);
        end else begin
            rad_sat = i_req.radius;
        end
    end

    assign rad_ext = $signed(D_W'(rad_sat));

    // d = 3 - 2r
    assign o_job.radius = rad_sat;
    assign o_job.colour = i_req.pen_colour;
    assign o_job.d_init = D_W'(D_BIAS) - (rad_ext <<< 1);

    assign o_job_valid = i_req.valid;
    assign i_req.ready = i_job_ready;

endmodule

FILE: hw/rtl/mcr_queue.sv
// ----------------------------------------------------------------------------
// mcr_queue
// short job queue between the request front and the stepping back end
// ----------------------------------------------------------------------------
module mcr_queue #(
    parameter int DEPTH = mcr_pkg::QUEUE_DEPTH_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push_valid,
    output logic          o_push_ready,
    input  mcr_pkg::t_job i_push_job,
    output logic          o_pop_valid,
    input  logic          i_pop_ready,
    output mcr_pkg::t_job o_pop_job
);
    import mcr_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_QW = $clog2(DEPTH + 1);

    t_job              r_mem [DEPTH];
    logic [PTR_W-1:0]  r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0]  r_rd_ptr, n_rd_ptr;
    logic [CNT_QW-1:0] r_count, n_count;
    logic              push, pop;

    assign o_push_ready = (r_count != CNT_QW'(DEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign o_pop_job    = r_mem[r_rd_ptr];

    assign push = i_push_valid && o_push_ready;
    assign pop  = o_pop_valid && i_pop_ready;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (push && !pop) begin
            n_count = r_count + 1'b1;
        end else if (pop && !push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_push_job;
        end
    end

endmodule

FILE: hw/rtl/mcr_back.sv
// ----------------------------------------------------------------------------
// mcr_back
// octant stepper: one decision step per word, eight mirrored pixels registered
// ----------------------------------------------------------------------------
module mcr_back #(
    parameter int COORD_BITS = mcr_pkg::COORD_BITS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_job_valid,
    output logic                       o_job_ready,
    input  mcr_pkg::t_job              i_job,
    input  logic [mcr_pkg::CEN_W-1:0]  i_center_x,
    input  logic [mcr_pkg::CEN_W-1:0]  i_center_y,
    mcr_pix_if.source                  o_pix
);
    import mcr_pkg::*;

    t_back_state            r_state, n_state;
    logic signed [AB_W-1:0] r_a, r_b;
    logic signed [D_W-1:0]  r_d;
    logic [CNT_W-1:0]       r_cnt;
    logic [COL_W-1:0]       r_colour;

    logic                   r_out_valid;
    logic [POINT_W-1:0]     r_oct [8];
    logic [COL_W-1:0]       r_out_colour;
    logic                   r_out_last;

    logic                   emit_go;
    logic [CNT_W-1:0]       cnt_next;
    logic                   last;
    logic signed [D_W-1:0]  a_d, b_d;

    logic [COORD_BITS-1:0]  cx, cy, a_c, b_c;
    logic [POINT_W-1:0]     pts [8];

    function automatic logic [POINT_W-1:0] pack_point(
        input logic [COORD_BITS-1:0] px,
        input logic [COORD_BITS-1:0] py
    );
        logic [2*COORD_BITS-1:0] both;
        logic [31:0]             wide;
        both = {py, px};
        wide = 32'(both);
        return wide[POINT_W-1:0];
    endfunction

    assign o_job_ready = (r_state == ST_IDLE);
    assign emit_go     = (r_state == ST_RUN) && (!r_out_valid || o_pix.ready);
    assign cnt_next    = r_cnt + 1'b1;
    // walk ends once the octant is crossed or the word budget is used up
    assign last        = !((r_a <= r_b) && (cnt_next < CNT_W'(MAX_RESULTS)));

    assign a_d = D_W'(r_a);
    assign b_d = D_W'(r_b);

    assign cx  = COORD_BITS'(i_center_x);
    assign cy  = COORD_BITS'(i_center_y);
    assign a_c = COORD_BITS'(r_a);
    assign b_c = COORD_BITS'(r_b);

    assign pts[0] = pack_point(cx + a_c, cy + b_c);
    assign pts[1] = pack_point(cx + b_c, cy + a_c);
    assign pts[2] = pack_point(cx - b_c, cy + a_c);
    assign pts[3] = pack_point(cx + a_c, cy - b_c);
    assign pts[4] = pack_point(cx - a_c, cy - b_c);
    assign pts[5] = pack_point(cx - b_c, cy - a_c);
    assign pts[6] = pack_point(cx + b_c, cy - a_c);
    assign pts[7] = pack_point(cx - a_c, cy + b_c);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_job_valid) begin
                    n_state = ST_RUN;
                end
            end
            ST_RUN: begin
                if (emit_go && last) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (emit_go) begin
                r_out_valid <= 1'b1;
            end else if (o_pix.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // walk registers
    always_ff @(posedge i_clk) begin
        if ((r_state == ST_IDLE) && i_job_valid) begin
            r_a      <= '0;
            r_b      <= AB_W'(i_job.radius);
            r_d      <= i_job.d_init;
            r_cnt    <= '0;
            r_colour <= i_job.colour;
        end else if (emit_go && !last) begin
            r_cnt <= cnt_next;
            r_a   <= r_a + 1'b1;
            if (r_d <= 0) begin
                r_d <= r_d + (a_d <<< 2) + D_W'(STEP_KEEP);
            end else begin
                r_d <= r_d + ((a_d - b_d) <<< 2) + D_W'(STEP_DIAG);
                r_b <= r_b - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit_go) begin
            r_oct        <= pts;
            r_out_colour <= r_colour;
            r_out_last   <= last;
        end
    end

    assign o_pix.valid        = r_out_valid;
    assign o_pix.oct1_point   = r_oct[0];
    assign o_pix.oct2_point   = r_oct[1];
    assign o_pix.oct3_point   = r_oct[2];
    assign o_pix.oct4_point   = r_oct[3];
    assign o_pix.oct5_point   = r_oct[4];
    assign o_pix.oct6_point   = r_oct[5];
    assign o_pix.oct7_point   = r_oct[6];
    assign o_pix.oct8_point   = r_oct[7];
    assign o_pix.pixel_colour = r_out_colour;
    assign o_pix.last_step    = r_out_last;

endmodule

FILE: hw/rtl/midpoint_circle_rasterizer.sv
// ----------------------------------------------------------------------------
// midpoint_circle_rasterizer
// midpoint circle walk emitting eight octant-mirrored pixels per word
// ----------------------------------------------------------------------------
//  channel  dir  handshake      word
//  i_req    in   valid/ready    radius, pen_colour
//  o_pix    out  valid/ready    oct1..oct8 points, pixel_colour, last_step
//  i_cfg    in   valid/ready    index, data (centre x / centre y)
//
//  a circle of radius r gives about r/sqrt(2)+2 words, at most 48, one per cycle
//  from the stepper; the stepper takes a new circle the cycle after its last word
//  the request queue holds QUEUE_DEPTH circles so requests are taken while a walk runs
//  reset is synchronous, active low; the centre returns to (300, 200)
//  a stall on o_pix holds the stepper, the queue keeps taking requests until full
//  i_cfg is always ready
// ----------------------------------------------------------------------------
module midpoint_circle_rasterizer #(
    parameter int COORD_BITS  = mcr_pkg::COORD_BITS_DEF,
    parameter int QUEUE_DEPTH = mcr_pkg::QUEUE_DEPTH_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    mcr_req_if.sink    i_req,
    mcr_pix_if.source  o_pix,
    mcr_cfg_if.sink    i_cfg
);
    import mcr_pkg::*;

    logic             push_valid, push_ready;
    t_job             push_job;
    logic             pop_valid, pop_ready;
    t_job             pop_job;
    logic [CEN_W-1:0] r_center_x, r_center_y;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_center_x <= CENTER_X_RESET;
            r_center_y <= CENTER_Y_RESET;
        end else if (i_cfg.valid) begin
            unique case (t_cfg_idx'(i_cfg.index))
                CFG_CENTER_X: r_center_x <= i_cfg.data;
                CFG_CENTER_Y: r_center_y <= i_cfg.data;
                default: ;
            endcase
        end
    end

    mcr_front u_front (
        .i_req       (i_req),
        .o_job_valid (push_valid),
        .i_job_ready (push_ready),
        .o_job       (push_job)
    );

    mcr_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (push_valid),
        .o_push_ready (push_ready),
        .i_push_job   (push_job),
        .o_pop_valid  (pop_valid),
        .i_pop_ready  (pop_ready),
        .o_pop_job    (pop_job)
    );

    mcr_back #(
        .COORD_BITS (COORD_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (pop_valid),
        .o_job_ready (pop_ready),
        .i_job       (pop_job),
        .i_center_x  (r_center_x),
        .i_center_y  (r_center_y),
        .o_pix       (o_pix)
    );

endmodule

FILE: hw/rtl/mcr_checker.sv
// ----------------------------------------------------------------------------
// mcr_checker
// port-level checks of the rasterizer, bound to the top level
// ----------------------------------------------------------------------------
module mcr_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_req_valid,
    input logic                        i_req_ready,
    input logic                        i_pix_valid,
    input logic                        i_pix_ready,
    input logic [mcr_pkg::POINT_W-1:0] i_pix_oct1,
    input logic [mcr_pkg::POINT_W-1:0] i_pix_oct8,
    input logic [mcr_pkg::COL_W-1:0]   i_pix_colour,
    input logic                        i_pix_last
);
    import mcr_pkg::*;

    logic [3:0]       r_open;
    logic             r_mid;
    logic [COL_W-1:0] r_prev_col;
    logic             req_acc, pix_acc, pix_end;

    assign req_acc = i_req_valid && i_req_ready;
    assign pix_acc = i_pix_valid && i_pix_ready;
    assign pix_end = pix_acc && i_pix_last;

    // circles taken but not yet closed by a last word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_open <= '0;
            r_mid  <= 1'b0;
        end else begin
            if (req_acc && !pix_end) begin
                r_open <= r_open + 1'b1;
            end else if (pix_end && !req_acc) begin
                r_open <= r_open - 1'b1;
            end
            if (pix_acc) begin
                r_mid <= !i_pix_last;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (pix_acc) begin
            r_prev_col <= i_pix_colour;
        end
    end

    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_pix_valid)
        else $error("pixel valid after reset");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pix_valid && !i_pix_ready |=>
            i_pix_valid && $stable(i_pix_oct1) && $stable(i_pix_oct8)
            && $stable(i_pix_last))
        else $error("stalled pixel word changed");

    a_no_orphan_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pix_valid |-> r_open != '0)
        else $error("pixel word without an open circle");

    a_colour_steady: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pix_valid && r_mid |-> i_pix_colour == r_prev_col)
        else $error("colour changed inside a circle");

endmodule

bind midpoint_circle_rasterizer mcr_checker u_mcr_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_req_valid  (i_req.valid),
    .i_req_ready  (i_req.ready),
    .i_pix_valid  (o_pix.valid),
    .i_pix_ready  (o_pix.ready),
    .i_pix_oct1   (o_pix.oct1_point),
    .i_pix_oct8   (o_pix.oct8_point),
    .i_pix_colour (o_pix.pixel_colour),
    .i_pix_last   (o_pix.last_step)
);

FILE: tb/sv/midpoint_circle_rasterizer_tb.sv
// ----------------------------------------------------------------------------
// midpoint_circle_rasterizer_tb
// drives circle requests and centre writes into the rasterizer, predicts every
// pixel word of the midpoint walk and checks each word field by field, under
// random idling on both channels and one long output hold-off
// ----------------------------------------------------------------------------
module midpoint_circle_rasterizer_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import mcr_pkg::*;

    localparam int CLK_PERIOD  = 8;
    localparam int COORD_BITS  = COORD_BITS_DEF;
    localparam int N_RANDOM    = 113;
    localparam int N_CALM      = 20;
    localparam int HOLD_CYCLES = 400;
    localparam int TAIL_CYCLES = 20;
    localparam int IDLE_LIMIT  = 2500;
    localparam int MAX_REPORTS = 100;
    localparam logic [CEN_W-1:0] CEN_MAX = CEN_W'((1 << CEN_W) - 1);

    typedef struct packed {
        logic [7:0][POINT_W-1:0] pts;
        logic [COL_W-1:0]        colour;
        logic                    last_step;
    } t_pix_word;

    typedef struct packed {
        logic [CEN_W-1:0]   cen_x;
        logic [CEN_W-1:0]   cen_y;
        logic [RAD_W-1:0]   radius;
        logic [COL_W-1:0]   colour;
        logic               typed;
        logic [POINT_W-1:0] start_point;
    } t_circle_row;

    // start point of a radius-zero circle sits on the centre in all eight octants
    localparam int N_DIRECTED = 17;
    localparam t_circle_row DIRECTED_ROWS [N_DIRECTED] = '{
        '{10'd300,  10'd200,  6'd0,  4'd5,  1'b1, 24'h0C812C},
        '{10'd300,  10'd200,  6'd1,  4'd10, 1'b0, 24'h000000},
        '{10'd300,  10'd200,  6'd2,  4'd0,  1'b0, 24'h000000},
        '{10'd300,  10'd200,  6'd63, 4'd15, 1'b0, 24'h000000},
        '{10'd300,  10'd200,  6'd42, 4'd3,  1'b0, 24'h000000},
        '{10'd300,  10'd200,  6'd21, 4'd12, 1'b0, 24'h000000},
        '{10'd0,    10'd0,    6'd0,  4'd9,  1'b1, 24'h000000},
        '{10'd0,    10'd0,    6'd63, 4'd6,  1'b0, 24'h000000},
        '{10'd0,    10'd0,    6'd1,  4'd1,  1'b0, 24'h000000},
        '{10'd0,    10'd0,    6'd7,  4'd14, 1'b0, 24'h000000},
        '{10'd1023, 10'd1023, 6'd0,  4'd2,  1'b1, 24'h3FF3FF},
        '{10'd1023, 10'd1023, 6'd63, 4'd11, 1'b0, 24'h000000},
        '{10'd1023, 10'd1023, 6'd33, 4'd4,  1'b0, 24'h000000},
        '{10'd1023, 10'd0,    6'd0,  4'd7,  1'b1, 24'h0003FF},
        '{10'd1023, 10'd0,    6'd45, 4'd8,  1'b0, 24'h000000},
        '{10'd0,    10'd1023, 6'd0,  4'd13, 1'b1, 24'h3FF000},
        '{10'd0,    10'd1023, 6'd62, 4'd15, 1'b0, 24'h000000}
    };

    logic i_clk;
    logic i_rst_n;

    mcr_req_if req_ch ();
    mcr_pix_if pix_ch ();
    mcr_cfg_if cfg_ch ();

    midpoint_circle_rasterizer i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_pix   (pix_ch),
        .i_cfg   (cfg_ch)
    );

    logic [CEN_W-1:0] centre_x;
    logic [CEN_W-1:0] centre_y;
    t_pix_word        pending_words[$];
    int               mismatches  = 0;
    int               words_seen  = 0;
    bit               idling_on   = 1'b1;
    bit               flood_armed = 1'b0;

    initial i_clk = 1'b0;
    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    task automatic report_mismatch(input string msg);
        if (mismatches < MAX_REPORTS) begin
            $display("[%0t] mismatch: %s", $time, msg);
        end
        mismatches++;
    endtask

    function automatic logic [POINT_W-1:0] pack_xy(input int px, input int py);
        return POINT_W'({py[COORD_BITS-1:0], px[COORD_BITS-1:0]});
    endfunction

    function automatic t_pix_word mirror_octants(input int a, input int b,
                                                 input logic [COL_W-1:0] colour);
        t_pix_word w;
        int cx;
        int cy;
        cx = int'(centre_x);
        cy = int'(centre_y);
        w.pts[0]    = pack_xy(cx + a, cy + b);
        w.pts[1]    = pack_xy(cx + b, cy + a);
        w.pts[2]    = pack_xy(cx - b, cy + a);
        w.pts[3]    = pack_xy(cx + a, cy - b);
        w.pts[4]    = pack_xy(cx - a, cy - b);
        w.pts[5]    = pack_xy(cx - b, cy - a);
        w.pts[6]    = pack_xy(cx + b, cy - a);
        w.pts[7]    = pack_xy(cx - a, cy + b);
        w.colour    = colour;
        w.last_step = 1'b0;
        return w;
    endfunction

    // midpoint walk over the first octant, one word per step
    function automatic void queue_circle_words(input logic [RAD_W-1:0] radius,
                                               input logic [COL_W-1:0] colour);
        int a;
        int b;
        int d;
        int n;
        b = (int'(radius) > MAX_RADIUS) ? MAX_RADIUS : int'(radius);
        a = 0;
        d = 3 - 2 * b;
        pending_words.push_back(mirror_octants(a, b, colour));
        n = 1;
        while (a <= b && n < MAX_RESULTS) begin
            if (d <= 0) begin
                d = d + 4 * a + 6;
            end else begin
                d = d + 4 * a - 4 * b + 10;
                b = b - 1;
            end
            a = a + 1;
            pending_words.push_back(mirror_octants(a, b, colour));
            n++;
        end
        pending_words[pending_words.size() - 1].last_step = 1'b1;
    endfunction

    function automatic logic [CEN_W-1:0] pick_coord();
        case ($urandom_range(0, 3))
            0: return '0;
            1: return CEN_MAX;
            default: return CEN_W'($urandom_range(0, int'(CEN_MAX)));
        endcase
    endfunction

    function automatic logic [RAD_W-1:0] pick_radius();
        case ($urandom_range(0, 5))
            0: return RAD_W'($urandom_range(0, 3));
            1: return RAD_W'($urandom_range(50, MAX_RADIUS));
            default: return RAD_W'($urandom_range(0, MAX_RADIUS));
        endcase
    endfunction

    task automatic offer_circle(input logic [RAD_W-1:0] radius,
                                input logic [COL_W-1:0] colour,
                                input logic typed, input logic [POINT_W-1:0] start_point);
        int gap;
        int head_idx;
        if (idling_on && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 19);
            @(negedge i_clk);
            req_ch.valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        req_ch.valid      <= 1'b1;
        req_ch.radius     <= radius;
        req_ch.pen_colour <= colour;
        @(posedge i_clk);
        while (!req_ch.ready) @(posedge i_clk);
        head_idx = pending_words.size();
        queue_circle_words(radius, colour);
        if (typed) begin
            pending_words[head_idx].pts = {8{start_point}};
        end
    endtask

    // centre moves only once every word of the previous circles is out
    task automatic set_centre(input logic [CEN_W-1:0] x, input logic [CEN_W-1:0] y);
        @(negedge i_clk);
        req_ch.valid <= 1'b0;
        while (pending_words.size() != 0) @(posedge i_clk);
        @(negedge i_clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= CFG_CENTER_X;
        cfg_ch.data  <= x;
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
        centre_x = x;
        @(negedge i_clk);
        cfg_ch.index <= CFG_CENTER_Y;
        cfg_ch.data  <= y;
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
        centre_y = y;
        @(negedge i_clk);
        cfg_ch.valid <= 1'b0;
    endtask

    // output side: random stall bursts plus one long hold while requests pile up
    initial begin
        int stall_left;
        bit flood_done;
        stall_left   = 0;
        flood_done   = 1'b0;
        pix_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (flood_armed && !flood_done) begin
                stall_left = HOLD_CYCLES;
                flood_done = 1'b1;
            end else if (stall_left == 0 && idling_on && $urandom_range(0, 7) == 0) begin
                stall_left = $urandom_range(1, 19);
            end
            if (stall_left > 0) begin
                pix_ch.ready <= 1'b0;
                stall_left--;
            end else begin
                pix_ch.ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        t_pix_word got;
        t_pix_word want;
        if (i_rst_n && pix_ch.valid && pix_ch.ready) begin
            got.pts[0]    = pix_ch.oct1_point;
            got.pts[1]    = pix_ch.oct2_point;
            got.pts[2]    = pix_ch.oct3_point;
            got.pts[3]    = pix_ch.oct4_point;
            got.pts[4]    = pix_ch.oct5_point;
            got.pts[5]    = pix_ch.oct6_point;
            got.pts[6]    = pix_ch.oct7_point;
            got.pts[7]    = pix_ch.oct8_point;
            got.colour    = pix_ch.pixel_colour;
            got.last_step = pix_ch.last_step;
            if (pending_words.size() == 0) begin
                report_mismatch($sformatf("word %0d arrived with none expected", words_seen));
            end else begin
                want = pending_words.pop_front();
                for (int k = 0; k < 8; k++) begin
                    if (got.pts[k] !== want.pts[k]) begin
                        report_mismatch($sformatf("word %0d oct%0d_point got %06h want %06h",
                                                  words_seen, k + 1, got.pts[k], want.pts[k]));
                    end
                end
                if (got.colour !== want.colour) begin
                    report_mismatch($sformatf("word %0d pixel_colour got %0d want %0d",
                                              words_seen, got.colour, want.colour));
                end
                if (got.last_step !== want.last_step) begin
                    report_mismatch($sformatf("word %0d last_step got %0b want %0b",
                                              words_seen, got.last_step, want.last_step));
                end
            end
            words_seen++;
        end
    end

    // watchdog on cycles with no handshake on any channel
    initial begin
        int quiet_run;
        quiet_run = 0;
        while (quiet_run < IDLE_LIMIT) begin
            @(posedge i_clk);
            if ((req_ch.valid && req_ch.ready) || (pix_ch.valid && pix_ch.ready)
                    || (cfg_ch.valid && cfg_ch.ready)) begin
                quiet_run = 0;
            end else begin
                quiet_run++;
            end
        end
        $display("[%0t] no handshake for %0d cycles", $time, IDLE_LIMIT);
        $display("Test completed with failures");
        $finish;
    end

    initial begin
        int next_move;
        t_circle_row row;
        req_ch.valid      = 1'b0;
        req_ch.radius     = '0;
        req_ch.pen_colour = '0;
        cfg_ch.valid      = 1'b0;
        cfg_ch.index      = CFG_CENTER_X;
        cfg_ch.data       = '0;
        i_rst_n           = 1'b0;
        centre_x          = CENTER_X_RESET;
        centre_y          = CENTER_Y_RESET;
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (int i = 0; i < N_DIRECTED; i++) begin
            row = DIRECTED_ROWS[i];
            if (row.cen_x != centre_x || row.cen_y != centre_y) begin
                set_centre(row.cen_x, row.cen_y);
            end
            offer_circle(row.radius, row.colour, row.typed, row.start_point);
        end

        flood_armed = 1'b1;
        next_move = $urandom_range(25, 35);
        for (int n = 0; n < N_RANDOM; n++) begin
            if (n == N_RANDOM - N_CALM) begin
                idling_on = 1'b0;
            end
            if (n == next_move) begin
                set_centre(pick_coord(), pick_coord());
                next_move += $urandom_range(20, 35);
            end
            offer_circle(pick_radius(), COL_W'($urandom_range(0, 15)), 1'b0, '0);
        end

        @(negedge i_clk);
        req_ch.valid <= 1'b0;
        while (pending_words.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (pending_words.size() != 0) begin
            report_mismatch($sformatf("%0d words never arrived", pending_words.size()));
        end
        if (mismatches == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
